[rtl/odo_pkg.sv]
// Types, constants and the arctangent table shared by the odometry modules.
package odo_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 24;

	// field widths
	localparam int unsigned STEPS_W    = 32;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned HEAD_W     = 32;
	localparam int unsigned SPEED_W    = 24;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned TPS_W      = 18;
	localparam int unsigned INV_W      = 24;
	localparam int unsigned RATE_W     = 10;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	// internal widths
	localparam int unsigned DELTA_W    = 33;
	localparam int unsigned MUL_W      = 33;
	localparam int unsigned PROD_W     = 2 * MUL_W;
	localparam int unsigned TRAVEL_W   = 51;
	localparam int unsigned TSUM_W     = TRAVEL_W + 1;
	localparam int unsigned TSUM_R_W   = TSUM_W - 8;
	localparam int unsigned RATEP_W    = TPS_W + RATE_W;
	localparam int unsigned DIFF_W     = 40;
	localparam int unsigned DIFF_SPLIT = 20;
	localparam int unsigned ACC_W      = 64;
	localparam int unsigned ANG_W      = 34;
	localparam int unsigned TRIG_W     = 33;
	localparam int unsigned ATAN_LEN   = 30;
	localparam int unsigned ATAN_IW    = 5;

	// reset values of the configuration registers
	localparam logic [TPS_W-1:0]  TPS_RESET  = 18'd61768;
	localparam logic [INV_W-1:0]  INV_RESET  = 24'd364722;
	localparam logic [RATE_W-1:0] RATE_RESET = 10'd5;

	// angles in Q4.28, gain in Q1.30
	localparam logic signed [ANG_W-1:0]  TWO_PI_Q  = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0]  PI_Q      = 34'sd843314857;
	localparam logic signed [ANG_W-1:0]  HALF_PI_Q = 34'sd421657428;
	localparam logic signed [TRIG_W-1:0] GAIN_Q30  = 33'sd652032874;

	localparam logic signed [31:0] ATAN_Q28 [ATAN_LEN] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
		32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
		32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384,
		32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
		32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16,
		32'sd8, 32'sd4, 32'sd2, 32'sd1, 32'sd0
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRAVEL   = 2'd0,
		CFG_INV_AXLE = 2'd1,
		CFG_RATE     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [STEPS_W-1:0] left_steps;
		logic signed [STEPS_W-1:0] right_steps;
	} odo_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [HEAD_W-1:0]  heading;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic [TICK_W-1:0]         elapsed_ticks;
	} odo_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TL,
		ST_TR,
		ST_RATE,
		ST_PREP,
		ST_SPL,
		ST_SPR,
		ST_THH,
		ST_THL,
		ST_HACC,
		ST_DTH,
		ST_WRAP,
		ST_WAITC,
		ST_XM,
		ST_YM,
		ST_XY,
		ST_OUT
	} odo_state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_FOLD,
		CS_ITER,
		CS_SIGN,
		CS_DONE
	} cordic_state_t;

endpackage

[rtl/odo_mul.sv]
// Shared signed multiplier with a registered product.
module odo_mul (
	input  logic                              clk,
	input  logic signed [odo_pkg::MUL_W-1:0]  a,
	input  logic signed [odo_pkg::MUL_W-1:0]  b,
	output logic signed [odo_pkg::PROD_W-1:0] p
);
	import odo_pkg::*;

	logic signed [PROD_W-1:0] prod;

	assign prod = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		p <= prod;
	end

endmodule

[rtl/odo_cordic.sv]
// Iterative CORDIC rotator giving cosine and sine of a Q4.28 heading in Q1.30.
module odo_cordic #(
	parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [odo_pkg::HEAD_W-1:0] angle,
	output logic                              done,
	output logic signed [odo_pkg::TRIG_W-1:0] cos_val,
	output logic signed [odo_pkg::TRIG_W-1:0] sin_val
);
	import odo_pkg::*;

	localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

	cordic_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic signed [TRIG_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic neg_q;

	logic signed [ANG_W-1:0] ang_x, red;
	logic signed [TRIG_W-1:0] xs, ys;
	logic signed [ANG_W-1:0] at;

	// bring the heading into +-pi
	always_comb begin
		ang_x = ANG_W'(angle);
		if (ang_x > PI_Q) begin
			red = ang_x - TWO_PI_Q;
		end else if (ang_x < -PI_Q) begin
			red = ang_x + TWO_PI_Q;
		end else begin
			red = ang_x;
		end
	end

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = ANG_W'(ATAN_Q28[ATAN_IW'(cnt_q)]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q <= '0;
			end else if (state_q == CS_ITER) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		if (start) begin
			state_d = CS_FOLD;
		end else begin
			case (state_q)
				CS_FOLD: state_d = CS_ITER;
				CS_ITER: begin
					if (cnt_q == LAST_STEP) state_d = CS_SIGN;
				end
				CS_SIGN: state_d = CS_DONE;
				default: state_d = state_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			z_q   <= red;
			x_q   <= GAIN_Q30;
			y_q   <= '0;
			neg_q <= 1'b0;
		end else begin
			case (state_q)
				CS_FOLD: begin
					// fold into +-pi/2, flip the result later
					if (z_q > HALF_PI_Q) begin
						z_q   <= z_q - PI_Q;
						neg_q <= 1'b1;
					end else if (z_q < -HALF_PI_Q) begin
						z_q   <= z_q + PI_Q;
						neg_q <= 1'b1;
					end
				end
				CS_ITER: begin
					if (!z_q[ANG_W-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
				end
				CS_SIGN: begin
					if (neg_q) begin
						x_q <= -x_q;
						y_q <= -y_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign done    = (state_q == CS_DONE);
	assign cos_val = x_q;
	assign sin_val = y_q;

endmodule

[rtl/differential_drive_odometry.sv]
// Top level: differential-drive odometry sequencer, pose state and output register.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+------------------------------
//  in      | in_valid, in_ready, in_data      | in        | left/right step counters
//  out     | out_valid, out_ready, out_data   | out       | pose, speeds, tick count
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | register index and value
//          | cfg_data                         |           |
//
// A new word is accepted only from idle, once the last one is through; the CORDIC rotator
// sets the pace between acceptances, and the multiplies run beside it.
// The result lands in the output register in the sequencer's last step.
// Reset clears the pose, counters and handshake state and loads the register defaults.
// A stalled output holds the sequencer in its last step; cfg is always ready.
module differential_drive_odometry #(
	parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  odo_pkg::odo_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output odo_pkg::odo_out_t                    out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [odo_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [odo_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import odo_pkg::*;

	odo_state_t state_q, state_d;

	// configuration
	logic [TPS_W-1:0]  tps_q;
	logic [INV_W-1:0]  inv_q;
	logic [RATE_W-1:0] srate_q;

	// persistent state
	logic [STEPS_W-1:0]       last_l_q, last_r_q;
	logic [POS_W-1:0]         x_q, y_q;
	logic signed [HEAD_W-1:0] head_q;
	logic [TICK_W-1:0]        tick_q;

	// per-word working registers
	logic signed [DELTA_W-1:0]  dl_q, dr_q;
	logic signed [TRAVEL_W-1:0] tl_q, tr_q;
	logic [RATEP_W-1:0]         rate_q;
	logic signed [POS_W-1:0]    sum8_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic signed [SPEED_W-1:0]  spd_l_q, spd_r_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ANG_W-1:0]    dth_q;
	logic [POS_W-1:0]           rx_q, ry_q;

	logic     out_valid_q;
	odo_out_t out_q;

	logic in_acc, out_free;
	logic [STEPS_W-1:0] dl_raw, dr_raw;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic cor_start, cor_done;
	logic signed [TRIG_W-1:0] cos_v, sin_v;

	logic signed [TSUM_W-1:0]   tsum, tdiff;
	logic signed [TSUM_R_W-1:0] tsum_r;
	logic signed [POS_W-1:0]    sum8_d;
	logic signed [DIFF_W-1:0]   diff_d;
	logic signed [ACC_W-1:0]    dsh;
	logic signed [ANG_W-1:0]    dth_d, hsum, head_d;
	logic signed [PROD_W-1:0]   prod_r31;
	logic [POS_W-1:0]           rnd31;
	logic [POS_W-1:0]           y_new;

	function automatic logic signed [SPEED_W-1:0] speed_sat(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		logic signed [SPEED_W-1:0] s;
		r = (v + PROD_W'(128)) >>> 8;
		if (r > PROD_W'(8388607)) begin
			s = SPEED_W'(8388607);
		end else if (r < -PROD_W'(8388608)) begin
			s = SPEED_W'(-8388608);
		end else begin
			s = SPEED_W'(r);
		end
		return s;
	endfunction

	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign cor_start = in_acc;

	assign dl_raw = in_data.left_steps - last_l_q;
	assign dr_raw = in_data.right_steps - last_r_q;

	odo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	odo_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (head_q),
		.done    (cor_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// travel sum rounded and clamped, travel difference clamped
	always_comb begin
		tsum   = TSUM_W'(tl_q) + TSUM_W'(tr_q);
		tdiff  = TSUM_W'(tr_q) - TSUM_W'(tl_q);
		tsum_r = TSUM_R_W'((tsum + TSUM_W'(128)) >>> 8);
		if (tsum_r > TSUM_R_W'(2147483647)) begin
			sum8_d = POS_W'(2147483647);
		end else if (tsum_r < -TSUM_R_W'(2147483647)) begin
			sum8_d = -POS_W'(2147483647);
		end else begin
			sum8_d = POS_W'(tsum_r);
		end
		if (tdiff > (TSUM_W'(1) <<< 38)) begin
			diff_d = DIFF_W'(1) <<< 38;
		end else if (tdiff < -(TSUM_W'(1) <<< 38)) begin
			diff_d = -(DIFF_W'(1) <<< 38);
		end else begin
			diff_d = DIFF_W'(tdiff);
		end
	end

	// heading step and wrap
	always_comb begin
		dsh = acc_q >>> 12;
		if (dsh > ACC_W'(TWO_PI_Q)) begin
			dth_d = TWO_PI_Q;
		end else if (dsh < -ACC_W'(TWO_PI_Q)) begin
			dth_d = -TWO_PI_Q;
		end else begin
			dth_d = ANG_W'(dsh);
		end
		hsum = ANG_W'(head_q) + dth_q;
		if (hsum >= TWO_PI_Q) begin
			head_d = hsum - TWO_PI_Q;
		end else if (hsum <= -TWO_PI_Q) begin
			head_d = hsum + TWO_PI_Q;
		end else begin
			head_d = hsum;
		end
	end

	assign prod_r31 = mul_p + PROD_W'(1 << 30);
	assign rnd31    = prod_r31[31+POS_W-1:31];
	assign y_new    = y_q + ry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_TL;
			end
			ST_TL: begin
				mul_a   = dl_q;
				mul_b   = MUL_W'(tps_q);
				state_d = ST_TR;
			end
			ST_TR: begin
				mul_a   = dr_q;
				mul_b   = MUL_W'(tps_q);
				state_d = ST_RATE;
			end
			ST_RATE: begin
				mul_a   = MUL_W'(tps_q);
				mul_b   = MUL_W'(srate_q);
				state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_SPL;
			ST_SPL: begin
				mul_a   = dl_q;
				mul_b   = MUL_W'(rate_q);
				state_d = ST_SPR;
			end
			ST_SPR: begin
				mul_a   = dr_q;
				mul_b   = MUL_W'(rate_q);
				state_d = ST_THH;
			end
			ST_THH: begin
				mul_a   = MUL_W'($signed(diff_q[DIFF_W-1:DIFF_SPLIT]));
				mul_b   = MUL_W'(inv_q);
				state_d = ST_THL;
			end
			ST_THL: begin
				mul_a   = MUL_W'(diff_q[DIFF_SPLIT-1:0]);
				mul_b   = MUL_W'(inv_q);
				state_d = ST_HACC;
			end
			ST_HACC: state_d = ST_DTH;
			ST_DTH:  state_d = ST_WRAP;
			ST_WRAP: state_d = ST_WAITC;
			ST_WAITC: begin
				if (cor_done) state_d = ST_XM;
			end
			ST_XM: begin
				mul_a   = MUL_W'(sum8_q);
				mul_b   = cos_v;
				state_d = ST_YM;
			end
			ST_YM: begin
				mul_a   = MUL_W'(sum8_q);
				mul_b   = sin_v;
				state_d = ST_XY;
			end
			ST_XY: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration, pose state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= TPS_RESET;
			inv_q       <= INV_RESET;
			srate_q     <= RATE_RESET;
			last_l_q    <= '0;
			last_r_q    <= '0;
			x_q         <= '0;
			y_q         <= '0;
			head_q      <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TRAVEL:   tps_q   <= cfg_data[TPS_W-1:0];
					CFG_INV_AXLE: inv_q   <= cfg_data[INV_W-1:0];
					CFG_RATE:     srate_q <= cfg_data[RATE_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				last_l_q <= in_data.left_steps;
				last_r_q <= in_data.right_steps;
			end
			if (state_q == ST_WRAP) head_q <= HEAD_W'(head_d);
			if (state_q == ST_XY) x_q <= x_q + rx_q;
			if (state_q == ST_OUT && out_free) begin
				y_q         <= y_new;
				tick_q      <= tick_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dl_q <= $signed({dl_raw[STEPS_W-1], dl_raw});
			dr_q <= DELTA_W'(0) - $signed({dr_raw[STEPS_W-1], dr_raw});
		end
		case (state_q)
			ST_TR:   tl_q    <= TRAVEL_W'(mul_p);
			ST_RATE: tr_q    <= TRAVEL_W'(mul_p);
			ST_PREP: begin
				rate_q <= mul_p[RATEP_W-1:0];
				sum8_q <= sum8_d;
				diff_q <= diff_d;
			end
			ST_SPR:  spd_l_q <= speed_sat(mul_p);
			ST_THH:  spd_r_q <= speed_sat(mul_p);
			ST_THL:  acc_q   <= ACC_W'(mul_p);
			// combine the high and low partial products, add the rounding half
			ST_HACC: acc_q   <= (acc_q <<< DIFF_SPLIT) + ACC_W'(mul_p) + ACC_W'(2048);
			ST_DTH:  dth_q   <= dth_d;
			ST_YM:   rx_q    <= rnd31;
			ST_XY:   ry_q    <= rnd31;
			ST_OUT: begin
				if (out_free) begin
					out_q.pos_x         <= x_q;
					out_q.pos_y         <= y_new;
					out_q.heading       <= head_q;
					out_q.left_speed    <= spd_l_q;
					out_q.right_speed   <= spd_r_q;
					out_q.elapsed_ticks <= tick_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for differential_drive_odometry: random ticks, checks pose, speeds, count.
`timescale 1ns / 1ps

class odo_scoreboard;
	// register copies, masked to width
	bit [17:0] travel_q16;
	bit [23:0] inv_axle_q24;
	bit [9:0]  rate_hz;
	// pose state
	bit [31:0] prev_left;
	bit [31:0] prev_right;
	bit [31:0] x_cm;
	bit [31:0] y_cm;
	bit [31:0] head_rad;
	bit [31:0] ticks;
	odo_pkg::odo_out_t pose_due[$];
	int mismatches;
	int compared;
	int wraps;
	int speed_sats;

	function new();
		travel_q16   = odo_pkg::TPS_RESET;
		inv_axle_q24 = odo_pkg::INV_RESET;
		rate_hz      = odo_pkg::RATE_RESET;
		prev_left    = '0;
		prev_right   = '0;
		x_cm         = '0;
		y_cm         = '0;
		head_rad     = '0;
		ticks        = '0;
		mismatches   = 0;
		compared     = 0;
		wraps        = 0;
		speed_sats   = 0;
	endfunction

	function void set_reg(logic [odo_pkg::CFG_IDX_W-1:0] idx,
		logic [odo_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			odo_pkg::CFG_TRAVEL:   travel_q16 = val[17:0];
			odo_pkg::CFG_INV_AXLE: inv_axle_q24 = val;
			odo_pkg::CFG_RATE:     rate_hz = val[9:0];
			default: ;
		endcase
	endfunction

	// shift right, rounding half up
	function longint rshift_round(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function void rotate(input longint ang, output longint cosv, output longint sinv);
		longint two_pi;
		longint pi;
		longint half_pi;
		longint cx;
		longint cy;
		longint cz;
		longint nx;
		bit flip;
		two_pi  = longint'(odo_pkg::TWO_PI_Q);
		pi      = longint'(odo_pkg::PI_Q);
		half_pi = longint'(odo_pkg::HALF_PI_Q);
		flip    = 1'b0;
		if (ang > pi) ang -= two_pi;
		if (ang < -pi) ang += two_pi;
		// fold into the right half plane, negate the result afterwards
		if (ang > half_pi) begin
			ang -= pi;
			flip = 1'b1;
		end else if (ang < -half_pi) begin
			ang += pi;
			flip = 1'b1;
		end
		cx = longint'(odo_pkg::GAIN_Q30);
		cy = 0;
		cz = ang;
		for (int i = 0; i < odo_pkg::CORDIC_STEPS_DEF && i < odo_pkg::ATAN_LEN; i++) begin
			if (cz >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				cz -= longint'(odo_pkg::ATAN_Q28[i]);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				cz += longint'(odo_pkg::ATAN_Q28[i]);
			end
			cx = nx;
		end
		cosv = flip ? -cx : cx;
		sinv = flip ? -cy : cy;
	endfunction

	function logic [23:0] speed_of(longint travel);
		longint v;
		longint c;
		v = rshift_round(travel * longint'(rate_hz), 8);
		c = clip(v, -64'sd8388608, 64'sd8388607);
		if (c != v) speed_sats++;
		return c[23:0];
	endfunction

	function void note_tick(odo_pkg::odo_in_t w);
		bit [31:0] lcnt;
		bit [31:0] rcnt;
		bit [31:0] dl32;
		bit [31:0] dr32;
		longint dl;
		longint dr;
		longint tl;
		longint tr;
		longint h;
		longint c;
		longint s;
		longint sum8;
		longint diff;
		longint dth;
		longint two_pi;
		odo_pkg::odo_out_t e;
		two_pi = longint'(odo_pkg::TWO_PI_Q);
		lcnt = w.left_steps;
		rcnt = w.right_steps;
		dl32 = lcnt - prev_left;
		dr32 = rcnt - prev_right;
		dl = longint'($signed(dl32));
		dr = -longint'($signed(dr32));
		tl = dl * longint'(travel_q16);
		tr = dr * longint'(travel_q16);
		h = longint'($signed(head_rad));
		// position moves along the heading held before this tick
		rotate(h, c, s);
		sum8 = clip(rshift_round(tl + tr, 8), -64'sd2147483647, 64'sd2147483647);
		x_cm = x_cm + 32'(rshift_round(sum8 * c, 31));
		y_cm = y_cm + 32'(rshift_round(sum8 * s, 31));
		diff = clip(tr - tl, -(longint'(1) << 38), longint'(1) << 38);
		dth = clip(rshift_round(diff * longint'(inv_axle_q24), 12), -two_pi, two_pi);
		h += dth;
		if (h >= two_pi) begin
			h -= two_pi;
			wraps++;
		end else if (h <= -two_pi) begin
			h += two_pi;
			wraps++;
		end
		head_rad = h[31:0];
		prev_left = lcnt;
		prev_right = rcnt;
		ticks = ticks + 1;
		e.pos_x = x_cm;
		e.pos_y = y_cm;
		e.heading = head_rad;
		e.left_speed = speed_of(tl);
		e.right_speed = speed_of(tr);
		e.elapsed_ticks = ticks;
		pose_due.push_back(e);
	endfunction

	function void compare(string what, logic signed [63:0] want, logic signed [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d %s: expected %0d (0x%0h), got %0d (0x%0h)",
					compared, what, want, want, got, got);
		end
	endfunction

	function void check_pose(odo_pkg::odo_out_t got);
		odo_pkg::odo_out_t e;
		if (pose_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with no tick pending: 0x%0h", got);
			return;
		end
		e = pose_due.pop_front();
		compare("pos_x", e.pos_x, got.pos_x);
		compare("pos_y", e.pos_y, got.pos_y);
		compare("heading", e.heading, got.heading);
		compare("left_speed", e.left_speed, got.left_speed);
		compare("right_speed", e.right_speed, got.right_speed);
		compare("elapsed_ticks", e.elapsed_ticks, got.elapsed_ticks);
		compared++;
	endfunction
endclass

module tb_top;
	import odo_pkg::*;

	localparam int unsigned STEPS = CORDIC_STEPS_DEF;
	localparam int SETTLE = STEPS + 8;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 190;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	odo_in_t in_data;
	logic out_valid;
	logic out_ready;
	odo_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	odo_scoreboard sb;
	logic [31:0] cur_left;
	logic [31:0] cur_right;
	bit calm;
	bit hold_req;
	int hold_left;
	int ticks_sent;
	int reg_writes;
	int settings;

	differential_drive_odometry #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// receiver: check each accepted word, stall at random or for a long hold
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_pose(out_data);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	task automatic send_tick(input odo_in_t w);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 35) gap = $urandom_range(1, 45);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(w);
		ticks_sent++;
	endtask

	// hold valid across the whole burst of register words
	task automatic program_regs(input int unsigned tps, input int unsigned inv,
		input int unsigned rate);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = CFG_TRAVEL;
		idx[1] = CFG_INV_AXLE;
		idx[2] = CFG_RATE;
		idx[3] = CFG_SPARE;
		// junk above the register width must be dropped
		val[0] = (24'($urandom()) & ~24'h03FFFF) | 24'(tps);
		val[1] = 24'(inv);
		val[2] = (24'($urandom()) & ~24'h0003FF) | 24'(rate);
		val[3] = 24'($urandom());
		cfg_valid <= 1'b1;
		for (int k = 0; k < 4; k++) begin
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx[k], val[k]);
			reg_writes++;
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pose_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly plausible wheel motion, some noise and counter jumps
	function automatic odo_in_t next_tick();
		odo_in_t w;
		int span;
		int dl;
		int dr;
		int unsigned pick;
		pick = $urandom_range(99);
		span = ($urandom_range(9) == 0) ? 20000 : 400;
		dl = int'($urandom_range(2 * span)) - span;
		if (pick < 12) begin
			w.left_steps = $urandom();
			w.right_steps = $urandom();
		end else if (pick < 16) begin
			w.left_steps = cur_left + $urandom();
			w.right_steps = cur_right - $urandom();
		end else begin
			if (pick < 65)
				dr = -dl + int'($urandom_range(span / 4)) - span / 8;
			else if (pick < 85)
				dr = dl;
			else
				dr = int'($urandom_range(2 * span)) - span;
			w.left_steps = cur_left + dl;
			w.right_steps = cur_right + dr;
		end
		cur_left = w.left_steps;
		cur_right = w.right_steps;
		return w;
	endfunction

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		static int dir [21][2] = '{
			'{0, 0}, '{100, -100}, '{250, -250}, '{250, -250}, '{350, -250},
			'{350, -350}, '{450, -250}, '{550, -150}, '{650, -50}, '{750, 50},
			'{650, -50}, '{550, -150}, '{450, -250}, '{350, -350}, '{-100, 100},
			'{32'sh7FFFFFFF, 32'sh80000000}, '{32'sh80000000, 32'sh7FFFFFFF},
			'{0, -1}, '{-1, 0}, '{-1, 0}, '{200, -200}
		};
		odo_in_t w;
		int unsigned tps;
		int unsigned inv;
		int unsigned rate;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		ticks_sent = 0;
		reg_writes = 0;
		settings = 1;
		sb = new();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: standstill, straight, single wheel, spins, counter wrap
		foreach (dir[i]) begin
			w.left_steps = dir[i][0];
			w.right_steps = dir[i][1];
			send_tick(w);
		end
		cur_left = w.left_steps;
		cur_right = w.right_steps;
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin tps = 262143; inv = 16777215; rate = 1023; end
				1: begin tps = 0; inv = 0; rate = 0; end
				2: begin tps = 1; inv = 1; rate = 1; end
				3: begin tps = TPS_RESET; inv = INV_RESET; rate = 1000; end
				6: begin tps = TPS_RESET; inv = INV_RESET; rate = RATE_RESET; end
				default: begin
					tps = $urandom_range(262143);
					inv = $urandom_range(16777215);
					rate = $urandom_range(1, 1000);
				end
			endcase
			program_regs(tps, inv, rate);
			calm = (p == 2);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				// stall the receiver long enough to back up the input
				if (p == 4 && n == 40) hold_req = 1'b1;
				send_tick(next_tick());
			end
			drain();
		end
		calm = 1'b0;

		$display("covered %0d ticks under %0d register settings, %0d register writes",
			ticks_sent, settings, reg_writes);
		$display("compared %0d results: %0d heading wraps, %0d saturated speeds, %0d mismatches",
			sb.compared, sb.wraps, sb.speed_sats, sb.mismatches);
		if (sb.mismatches == 0 && sb.pose_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/odo_pkg.sv
rtl/odo_mul.sv
rtl/odo_cordic.sv
rtl/differential_drive_odometry.sv
verif/tb_top.sv
